[hw/rtl/jxsl_pkg.sv]
// shared types, codes and the xmp namespace header table for the jpeg xmp locator
package jxsl_pkg;

    // default width of the byte position counter
    localparam int POSITION_BITS_DEFAULT = 32;

    // fixed field widths
    localparam int BYTE_BITS   = 8;
    localparam int STATUS_BITS = 2;
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int INDEX_BITS  = 5;

    // namespace header length and the smallest offset a found item can carry
    localparam logic [INDEX_BITS-1:0]  HDR_LEN        = 5'd29;
    localparam logic [OFFSET_BITS-1:0] MIN_XML_OFFSET = 32'd35;

    // marker bytes
    localparam logic [BYTE_BITS-1:0] MARKER_PREFIX = 8'hFF;
    localparam logic [BYTE_BITS-1:0] MARKER_SOI    = 8'hD8;
    localparam logic [BYTE_BITS-1:0] MARKER_SOS    = 8'hDA;
    localparam logic [BYTE_BITS-1:0] MARKER_EOI    = 8'hD9;
    localparam logic [BYTE_BITS-1:0] MARKER_STUFF  = 8'h00;
    localparam logic [BYTE_BITS-1:0] MARKER_RST0   = 8'hD0;
    localparam logic [BYTE_BITS-1:0] MARKER_RST7   = 8'hD7;
    localparam logic [BYTE_BITS-1:0] MARKER_APP1   = 8'hE1;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_JPEG  = 2'd1,
        STATUS_MALFORMED = 2'd2,
        STATUS_NO_XMP    = 2'd3
    } jxsl_status_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK,
        PH_FILL,
        PH_LENH,
        PH_LENL,
        PH_BODY,
        PH_DONE
    } jxsl_phase_t;

    // one result item
    typedef struct packed {
        jxsl_status_t           status;
        logic [OFFSET_BITS-1:0] xml_offset;
        logic [LENGTH_BITS-1:0] xml_length;
    } jxsl_result_t;

    // byte of the namespace header at a given index
    function automatic logic [BYTE_BITS-1:0] xmp_sig_byte(input logic [INDEX_BITS-1:0] idx);
        logic [BYTE_BITS-1:0] sig;
        case (idx)
            5'd0:    sig = 8'h68;
            5'd1:    sig = 8'h74;
            5'd2:    sig = 8'h74;
            5'd3:    sig = 8'h70;
            5'd4:    sig = 8'h3A;
            5'd5:    sig = 8'h2F;
            5'd6:    sig = 8'h2F;
            5'd7:    sig = 8'h6E;
            5'd8:    sig = 8'h73;
            5'd9:    sig = 8'h2E;
            5'd10:   sig = 8'h61;
            5'd11:   sig = 8'h64;
            5'd12:   sig = 8'h6F;
            5'd13:   sig = 8'h62;
            5'd14:   sig = 8'h65;
            5'd15:   sig = 8'h2E;
            5'd16:   sig = 8'h63;
            5'd17:   sig = 8'h6F;
            5'd18:   sig = 8'h6D;
            5'd19:   sig = 8'h2F;
            5'd20:   sig = 8'h78;
            5'd21:   sig = 8'h61;
            5'd22:   sig = 8'h70;
            5'd23:   sig = 8'h2F;
            5'd24:   sig = 8'h31;
            5'd25:   sig = 8'h2E;
            5'd26:   sig = 8'h30;
            5'd27:   sig = 8'h2F;
            default: sig = 8'h00;
        endcase
        return sig;
    endfunction

endpackage

[hw/rtl/jxsl_in_if.sv]
// byte stream channel of the jpeg xmp locator
interface jxsl_in_if
    import jxsl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] file_byte;
    logic                 end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

[hw/rtl/jxsl_out_if.sv]
// result channel of the jpeg xmp locator
interface jxsl_out_if
    import jxsl_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [OFFSET_BITS-1:0] xml_offset;
    logic [LENGTH_BITS-1:0] xml_length;

    modport source (output valid, output status, output xml_offset, output xml_length,
                    input ready);
    modport sink   (input valid, input status, input xml_offset, input xml_length,
                    output ready);
endinterface

[hw/rtl/jpeg_xmp_segment_locator.sv]
// top level of the jpeg xmp segment locator
//
// byte_stream carries a jpeg file one byte per item, end_of_file set on its
// final byte. result_stream carries exactly one item per file: status (found,
// not jpeg, malformed segment, no xmp before scan or end) and, when found,
// the file offset and length of the xml after the xmp namespace header.
// A byte is taken in every cycle while the result register is empty or being
// drained; the per-byte step is one pass of the parser logic.
// The result item shows in the cycle after the byte that decides it
// (the last payload byte of the xmp segment, or the failing byte).
// One byte per cycle; the result register is the only stall point.
// After the decision, bytes are swallowed until end_of_file, which restarts
// the parser for the next file.
// Reset clears the parser to expect a start-of-image marker and empties the
// result register. While the receiver stalls a waiting result, no byte is
// taken at all: byte_stream ready follows the free space of the result
// register, so input resumes in the cycle the pending result is taken.
module jpeg_xmp_segment_locator
    import jxsl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    jxsl_in_if.sink    byte_stream,
    jxsl_out_if.source result_stream
);

    logic         space;
    logic         accept;
    logic         res_valid;
    jxsl_result_t res;

    // a byte is accepted only when its possible result has room
    assign byte_stream.ready = space;
    assign accept            = byte_stream.valid && space;

    jxsl_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .file_byte   (byte_stream.file_byte),
        .end_of_file (byte_stream.end_of_file),
        .res_valid   (res_valid),
        .res         (res)
    );

    jxsl_result_reg u_result_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .space         (space),
        .result_stream (result_stream)
    );

endmodule

[hw/rtl/jxsl_parser.sv]
// marker segment walker: parse state registers and the per-byte step logic
module jxsl_parser
    import jxsl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [BYTE_BITS-1:0] file_byte,
    input  logic                 end_of_file,
    output logic                 res_valid,
    output jxsl_result_t         res
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    jxsl_phase_t              phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [BYTE_BITS-1:0]     marker_reg, marker_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [LENGTH_BITS-1:0]   rem_reg, rem_next;
    logic [INDEX_BITS-1:0]    idx_reg, idx_next;
    logic                     matching_reg, matching_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0]   pos_inc_offset;
    logic [LENGTH_BITS-1:0]   len_full;
    logic [LENGTH_BITS-1:0]   rem_dec;
    logic                     is_standalone;
    logic                     is_stop;
    logic                     len_short;
    logic                     seg_found;

    // saturating position increment and its 32-bit view
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    generate
        if (POSITION_BITS >= OFFSET_BITS) begin : g_offset_trunc
            assign pos_inc_offset = pos_inc[OFFSET_BITS-1:0];
        end else begin : g_offset_ext
            assign pos_inc_offset = {{(OFFSET_BITS-POSITION_BITS){1'b0}}, pos_inc};
        end
    endgenerate

    // byte classification
    assign len_full      = {len_reg[LENGTH_BITS-1:BYTE_BITS], file_byte};
    assign rem_dec       = rem_reg - 1'b1;
    assign is_standalone = (file_byte == MARKER_STUFF)
                           || ((file_byte >= MARKER_RST0) && (file_byte <= MARKER_RST7));
    assign is_stop       = (file_byte == MARKER_SOS) || (file_byte == MARKER_EOI);
    assign len_short     = (len_full < 16'd2);

    // segment fully matched once the last payload byte is in
    always_comb
    begin
        seg_found = 1'b0;
        if (matching_reg && (idx_reg < HDR_LEN)) begin
            seg_found = (file_byte == xmp_sig_byte(idx_reg)) && (idx_reg + 1'b1 == HDR_LEN);
        end else begin
            seg_found = matching_reg && (idx_reg == HDR_LEN);
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_SOI0:
                    phase_next = (file_byte != MARKER_PREFIX || end_of_file) ? PH_DONE : PH_SOI1;
                PH_SOI1:
                    phase_next = (file_byte != MARKER_SOI || end_of_file) ? PH_DONE : PH_MARK;
                PH_MARK:
                    phase_next = (end_of_file || file_byte != MARKER_PREFIX) ? PH_DONE : PH_FILL;
                PH_FILL:
                begin
                    if (end_of_file || is_stop) begin
                        phase_next = PH_DONE;
                    end else if (file_byte == MARKER_PREFIX) begin
                        phase_next = PH_FILL;
                    end else if (is_standalone) begin
                        phase_next = PH_MARK;
                    end else begin
                        phase_next = PH_LENH;
                    end
                end
                PH_LENH:
                    phase_next = end_of_file ? PH_DONE : PH_LENL;
                PH_LENL:
                begin
                    if (len_short || end_of_file) begin
                        phase_next = PH_DONE;
                    end else if (len_full == 16'd2) begin
                        phase_next = PH_MARK;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (rem_dec == '0) begin
                        phase_next = (seg_found || end_of_file) ? PH_DONE : PH_MARK;
                    end else begin
                        phase_next = end_of_file ? PH_DONE : PH_BODY;
                    end
                end
                PH_DONE:
                    phase_next = PH_DONE;
                default:
                    phase_next = PH_DONE;
            endcase
            // the final byte of a file always restarts the walker
            if (end_of_file) begin
                phase_next = PH_SOI0;
            end
        end
    end

    // datapath and result
    always_comb
    begin
        pos_next       = pos_reg;
        marker_next    = marker_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        matching_next  = matching_reg;
        start_next     = start_reg;
        res_valid      = 1'b0;
        res.status     = STATUS_FOUND;
        res.xml_offset = '0;
        res.xml_length = '0;
        if (accept) begin
            pos_next = pos_inc;
            unique case (phase_reg)
                PH_SOI0:
                begin
                    if (file_byte != MARKER_PREFIX || end_of_file) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_NOT_JPEG;
                    end
                end
                PH_SOI1:
                begin
                    if (file_byte != MARKER_SOI) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_NOT_JPEG;
                    end else if (end_of_file) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_NO_XMP;
                    end
                end
                PH_MARK:
                begin
                    if (end_of_file) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_NO_XMP;
                    end else if (file_byte != MARKER_PREFIX) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_MALFORMED;
                    end
                end
                PH_FILL:
                begin
                    if (file_byte == MARKER_PREFIX) begin
                        if (end_of_file) begin
                            res_valid  = 1'b1;
                            res.status = STATUS_MALFORMED;
                        end
                    end else begin
                        marker_next = file_byte;
                        if (is_stop || (is_standalone && end_of_file)) begin
                            res_valid  = 1'b1;
                            res.status = STATUS_NO_XMP;
                        end else if (!is_standalone && end_of_file) begin
                            res_valid  = 1'b1;
                            res.status = STATUS_MALFORMED;
                        end
                    end
                end
                PH_LENH:
                begin
                    len_next = {file_byte, {BYTE_BITS{1'b0}}};
                    if (end_of_file) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_MALFORMED;
                    end
                end
                PH_LENL:
                begin
                    len_next = len_full;
                    if (len_short) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_MALFORMED;
                    end else begin
                        rem_next      = len_full - 16'd2;
                        matching_next = (marker_reg == MARKER_APP1);
                        idx_next      = '0;
                        if (end_of_file) begin
                            res_valid  = 1'b1;
                            res.status = (len_full == 16'd2) ? STATUS_NO_XMP : STATUS_MALFORMED;
                        end
                    end
                end
                PH_BODY:
                begin
                    // header compare, one byte per item
                    if (matching_reg && (idx_reg < HDR_LEN)) begin
                        if (file_byte == xmp_sig_byte(idx_reg)) begin
                            idx_next = idx_reg + 1'b1;
                            if (idx_reg + 1'b1 == HDR_LEN) begin
                                start_next = pos_inc_offset;
                            end
                        end else begin
                            matching_next = 1'b0;
                        end
                    end
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        if (seg_found) begin
                            res_valid      = 1'b1;
                            res.status     = STATUS_FOUND;
                            res.xml_offset = start_next;
                            res.xml_length = len_reg - 16'd31;
                        end else if (end_of_file) begin
                            res_valid  = 1'b1;
                            res.status = STATUS_NO_XMP;
                        end
                    end else if (end_of_file) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_MALFORMED;
                    end
                end
                PH_DONE:
                begin
                    res_valid = 1'b0;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
            // final byte clears the walker state
            if (end_of_file) begin
                pos_next      = '0;
                marker_next   = '0;
                len_next      = '0;
                rem_next      = '0;
                idx_next      = '0;
                matching_next = 1'b0;
                start_next    = '0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_SOI0;
            pos_reg      <= '0;
            marker_reg   <= '0;
            len_reg      <= '0;
            rem_reg      <= '0;
            idx_reg      <= '0;
            matching_reg <= 1'b0;
            start_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            marker_reg   <= marker_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            idx_reg      <= idx_next;
            matching_reg <= matching_next;
            start_reg    <= start_next;
        end
    end

    // checks
    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> accept)
        else $error("result raised without an accepted item");

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_file |=> phase_reg == PH_SOI0)
        else $error("final byte did not restart the walker");

    a_silent_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_DONE |-> !res_valid)
        else $error("second result for one file");

    a_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == STATUS_FOUND |-> res.xml_offset >= MIN_XML_OFFSET)
        else $error("found offset lies before any possible header end");

endmodule

[hw/rtl/jxsl_result_reg.sv]
// result register between the parser and the result channel
module jxsl_result_reg
    import jxsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    input  jxsl_result_t res,
    output logic         space,
    jxsl_out_if.source   result_stream
);

    logic         valid_reg;
    jxsl_result_t data_reg;

    // a new item may enter when the register is empty or draining
    assign space = !valid_reg || result_stream.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (space) begin
            valid_reg <= res_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (space && res_valid) begin
            data_reg <= res;
        end
    end

    assign result_stream.valid      = valid_reg;
    assign result_stream.status     = data_reg.status;
    assign result_stream.xml_offset = data_reg.xml_offset;
    assign result_stream.xml_length = data_reg.xml_length;

endmodule
